// ----- design/lcft_pkg.sv -----
// ----------------------------------------------------------------------------
// lcft_pkg
// Shared sizes and the slot record of the lossy-counting frequency table.
// ----------------------------------------------------------------------------
package lcft_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
    localparam int KEY_BITS    = 32;
    localparam int COUNT_BITS  = 24;
    localparam int ENTRY_BITS  = ADDR_BITS + 1;
    localparam int BUCKET_BITS = 24;
    localparam int WIN_BITS    = 24;

    localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = {COUNT_BITS{1'b1}};
    localparam logic [BUCKET_BITS-1:0] BUCKET_MAX = {BUCKET_BITS{1'b1}};
    localparam logic [ADDR_BITS-1:0]   ADDR_LAST  = ADDR_BITS'(TABLE_DEPTH - 1);

    // One table slot as stored in the slot memory
    typedef struct packed {
        logic                  valid;
        logic [KEY_BITS-1:0]   key;
        logic [COUNT_BITS-1:0] count;
        logic [COUNT_BITS-1:0] delta;
    } slot_t;

    localparam int SLOT_BITS = $bits(slot_t);

endpackage

// ----- design/lossy_counting_frequency_table_core.sv -----
// ----------------------------------------------------------------------------
// lossy_counting_frequency_table_core
// Lossy-counting heavy-hitter table held in one slot memory.
// ----------------------------------------------------------------------------
// After reset the block sweeps the slot memory to clear it, with busy high. A
// request is taken when start is high and busy is low. The block then reads
// every slot once through the memory's single read port and writes the updated
// slot unless the key is dropped. Off a bucket boundary it shows the result
// with result_valid in the cycle after that write. On a bucket boundary a
// second sweep over the memory first frees stale slots, and the result is
// shown when that sweep ends. The result is shown for exactly one cycle and
// cannot be stalled; busy is already low in that cycle. window_size is to be
// written through cfg_valid/cfg_ready only while idle; the block does not enforce it.
module lossy_counting_frequency_table_core
    import lcft_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [WIN_BITS-1:0]    cfg_data,
    input  logic                   start,
    output logic                   busy,
    input  logic [31:0]            item_key,
    output logic                   result_valid,
    output logic [23:0]            item_count,
    output logic [23:0]            item_delta,
    output logic                   newly_entered,
    output logic                   dropped_full,
    output logic                   prune_done,
    output logic [10:0]            removed_entries,
    output logic [10:0]            live_entries,
    output logic [10:0]            peak_entries,
    output logic [23:0]            current_bucket
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_PRUNE
    } state_t;

    state_t                 state_reg, state_next;
    logic [ADDR_BITS-1:0]   addr_reg, addr_next;
    logic                   issued_all_reg, issued_all_next;
    logic                   pend_reg, pend_next;
    logic [ADDR_BITS-1:0]   pend_addr_reg, pend_addr_next;
    logic                   pend_last_reg, pend_last_next;
    logic [KEY_BITS-1:0]    key_reg, key_next;
    logic                   hit_found_reg, hit_found_next;
    logic [ADDR_BITS-1:0]   hit_idx_reg, hit_idx_next;
    logic [COUNT_BITS-1:0]  hit_count_reg, hit_count_next;
    logic [COUNT_BITS-1:0]  hit_delta_reg, hit_delta_next;
    logic                   free_found_reg, free_found_next;
    logic [ADDR_BITS-1:0]   free_idx_reg, free_idx_next;
    logic                   entered_reg, entered_next;
    logic [ADDR_BITS-1:0]   entered_idx_reg, entered_idx_next;
    logic                   dropped_reg, dropped_next;
    logic                   pruned_reg, pruned_next;
    logic [ENTRY_BITS-1:0]  removed_reg, removed_next;
    logic [ENTRY_BITS-1:0]  total_reg, total_next;
    logic [ENTRY_BITS-1:0]  peak_reg, peak_next;
    logic [BUCKET_BITS-1:0] bucket_reg, bucket_next;
    logic [WIN_BITS-1:0]    win_size_reg, win_size_next;
    logic [WIN_BITS-1:0]    win_pos_reg, win_pos_next;
    logic                   res_valid_reg, res_valid_next;
    logic [COUNT_BITS-1:0]  count_out_reg, count_out_next;
    logic [COUNT_BITS-1:0]  delta_out_reg, delta_out_next;

    logic                   ram_we;
    logic [ADDR_BITS-1:0]   ram_wa;
    slot_t                  ram_wd;
    logic                   ram_re;
    slot_t                  ram_rd;
    logic [SLOT_BITS-1:0]   ram_rd_bits;
    logic [COUNT_BITS:0]    age_sum;
    logic [ENTRY_BITS-1:0]  total_after;

    assign ram_rd = slot_t'(ram_rd_bits);

    lcft_slot_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (SLOT_BITS)
    ) u_slot_ram (
        .clk (clk),
        .we  (ram_we),
        .wa  (ram_wa),
        .wd  (ram_wd),
        .re  (ram_re),
        .ra  (addr_reg),
        .rd  (ram_rd_bits)
    );

    assign age_sum = {1'b0, ram_rd.count} + {1'b0, ram_rd.delta};

    // Next-state and datapath
    always_comb
    begin
        state_next       = state_reg;
        addr_next        = addr_reg;
        issued_all_next  = issued_all_reg;
        pend_next        = 1'b0;
        pend_addr_next   = pend_addr_reg;
        pend_last_next   = 1'b0;
        key_next         = key_reg;
        hit_found_next   = hit_found_reg;
        hit_idx_next     = hit_idx_reg;
        hit_count_next   = hit_count_reg;
        hit_delta_next   = hit_delta_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        entered_next     = entered_reg;
        entered_idx_next = entered_idx_reg;
        dropped_next     = dropped_reg;
        pruned_next      = pruned_reg;
        removed_next     = removed_reg;
        total_next       = total_reg;
        peak_next        = peak_reg;
        bucket_next      = bucket_reg;
        win_size_next    = win_size_reg;
        win_pos_next     = win_pos_reg;
        res_valid_next   = 1'b0;
        count_out_next   = count_out_reg;
        delta_out_next   = delta_out_reg;
        ram_we           = 1'b0;
        ram_wa           = addr_reg;
        ram_wd           = '0;
        ram_re           = 1'b0;
        total_after      = total_reg;

        if (cfg_valid)
        begin
            win_size_next = cfg_data;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Sweep zeros into every slot
                ram_we    = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == ADDR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    key_next        = item_key[KEY_BITS-1:0];
                    win_pos_next    = win_pos_reg + 1'b1;
                    addr_next       = '0;
                    issued_all_next = 1'b0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    entered_next    = 1'b0;
                    dropped_next    = 1'b0;
                    pruned_next     = 1'b0;
                    removed_next    = '0;
                    state_next      = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // Issue reads in address order
                if (!issued_all_reg)
                begin
                    ram_re          = 1'b1;
                    pend_next       = 1'b1;
                    pend_addr_next  = addr_reg;
                    pend_last_next  = (addr_reg == ADDR_LAST);
                    issued_all_next = (addr_reg == ADDR_LAST);
                    addr_next       = addr_reg + 1'b1;
                end
                // Catch the first matching slot and the first free slot
                if (pend_reg)
                begin
                    if (ram_rd.valid)
                    begin
                        if (!hit_found_reg && ram_rd.key == key_reg)
                        begin
                            hit_found_next = 1'b1;
                            hit_idx_next   = pend_addr_reg;
                            hit_count_next = ram_rd.count;
                            hit_delta_next = ram_rd.delta;
                        end
                    end
                    else if (!free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = pend_addr_reg;
                    end
                    if (pend_last_reg)
                    begin
                        state_next = ST_WRITE;
                    end
                end
            end

            ST_WRITE:
            begin
                ram_wd.valid = 1'b1;
                ram_wd.key   = key_reg;
                if (hit_found_reg)
                begin
                    // Bump the count, saturating
                    ram_we         = 1'b1;
                    ram_wa         = hit_idx_reg;
                    ram_wd.count   = (hit_count_reg == COUNT_MAX) ? hit_count_reg
                                                                  : hit_count_reg + 1'b1;
                    ram_wd.delta   = hit_delta_reg;
                    count_out_next = ram_wd.count;
                    delta_out_next = hit_delta_reg;
                end
                else if (free_found_reg)
                begin
                    // Enter the key into the first free slot
                    ram_we           = 1'b1;
                    ram_wa           = free_idx_reg;
                    ram_wd.count     = COUNT_BITS'(1);
                    ram_wd.delta     = COUNT_BITS'(bucket_reg - 1'b1);
                    total_after      = total_reg + 1'b1;
                    entered_next     = 1'b1;
                    entered_idx_next = free_idx_reg;
                    count_out_next   = ram_wd.count;
                    delta_out_next   = ram_wd.delta;
                end
                else
                begin
                    dropped_next   = 1'b1;
                    count_out_next = '0;
                    delta_out_next = '0;
                end
                total_next = total_after;

                if (win_pos_reg >= win_size_reg)
                begin
                    pruned_next     = 1'b1;
                    if (total_after > peak_reg)
                    begin
                        peak_next = total_after;
                    end
                    addr_next       = '0;
                    issued_all_next = 1'b0;
                    state_next      = ST_PRUNE;
                end
                else
                begin
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_PRUNE:
            begin
                if (!issued_all_reg)
                begin
                    ram_re          = 1'b1;
                    pend_next       = 1'b1;
                    pend_addr_next  = addr_reg;
                    pend_last_next  = (addr_reg == ADDR_LAST);
                    issued_all_next = (addr_reg == ADDR_LAST);
                    addr_next       = addr_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    // Free stale slots, sparing the one entered on this request
                    if (ram_rd.valid
                        && !(entered_reg && entered_idx_reg == pend_addr_reg)
                        && age_sum <= {1'b0, bucket_reg})
                    begin
                        ram_we       = 1'b1;
                        ram_wa       = pend_addr_reg;
                        ram_wd       = ram_rd;
                        ram_wd.valid = 1'b0;
                        removed_next = removed_reg + 1'b1;
                    end
                    if (pend_last_reg)
                    begin
                        total_next     = total_reg - removed_next;
                        win_pos_next   = '0;
                        bucket_next    = (bucket_reg == BUCKET_MAX) ? bucket_reg
                                                                    : bucket_reg + 1'b1;
                        res_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            addr_reg       <= '0;
            issued_all_reg <= 1'b0;
            pend_reg       <= 1'b0;
            pend_last_reg  <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            entered_reg    <= 1'b0;
            dropped_reg    <= 1'b0;
            pruned_reg     <= 1'b0;
            removed_reg    <= '0;
            total_reg      <= '0;
            peak_reg       <= '0;
            bucket_reg     <= BUCKET_BITS'(1);
            win_size_reg   <= WIN_BITS'(25000);
            win_pos_reg    <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            issued_all_reg <= issued_all_next;
            pend_reg       <= pend_next;
            pend_last_reg  <= pend_last_next;
            hit_found_reg  <= hit_found_next;
            free_found_reg <= free_found_next;
            entered_reg    <= entered_next;
            dropped_reg    <= dropped_next;
            pruned_reg     <= pruned_next;
            removed_reg    <= removed_next;
            total_reg      <= total_next;
            peak_reg       <= peak_next;
            bucket_reg     <= bucket_next;
            win_size_reg   <= win_size_next;
            win_pos_reg    <= win_pos_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_addr_reg   <= pend_addr_next;
        key_reg         <= key_next;
        hit_idx_reg     <= hit_idx_next;
        hit_count_reg   <= hit_count_next;
        hit_delta_reg   <= hit_delta_next;
        free_idx_reg    <= free_idx_next;
        entered_idx_reg <= entered_idx_next;
        count_out_reg   <= count_out_next;
        delta_out_reg   <= delta_out_next;
    end

    assign cfg_ready       = 1'b1;
    assign busy            = (state_reg != ST_IDLE);
    assign result_valid    = res_valid_reg;
    assign item_count      = count_out_reg;
    assign item_delta      = delta_out_reg;
    assign newly_entered   = entered_reg;
    assign dropped_full    = dropped_reg;
    assign prune_done      = pruned_reg;
    assign removed_entries = removed_reg;
    assign live_entries    = total_reg;
    assign peak_entries    = peak_reg;
    assign current_bucket  = bucket_reg;

    // A result only appears once the engine is back at rest
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> state_reg == ST_IDLE)
        else $error("result shown while engine busy");

    // An accepted request always starts a table scan
    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> state_reg == ST_SCAN)
        else $error("accepted request did not start scan");

    // The entry total never exceeds the table
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= ENTRY_BITS'(TABLE_DEPTH))
        else $error("entry total beyond table depth");

    // A dropped key never also takes a slot
    a_drop_excl: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> !(dropped_reg && entered_reg))
        else $error("key both dropped and entered");

endmodule

// ----- design/lcft_slot_ram.sv -----
// ----------------------------------------------------------------------------
// lcft_slot_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lcft_slot_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 81
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wa,
    input  logic [WIDTH-1:0]         wd,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] ra,
    output logic [WIDTH-1:0]         rd
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd <= mem[ra];
        end
    end

endmodule

// ----- verif/lossy_counting_frequency_table_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lossy_counting_frequency_table_core_test
// Self-checking bench for the lossy-counting frequency table. A short directed
// table with a few hand-computed results is followed by random key streams
// under several window sizes, one of which overfills the table. Every result is
// checked field by field against a local model of the slot table.
// ----------------------------------------------------------------------------
module lossy_counting_frequency_table_core_test;

    import lcft_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

    typedef struct packed {
        logic [23:0] count;
        logic [23:0] delta;
        logic        newly;
        logic        dropped;
        logic        pruned;
        logic [10:0] removed;
        logic [10:0] live;
        logic [10:0] peak;
        logic [23:0] bucket;
    } freq_result_t;

    typedef struct packed {
        row_kind_t    kind;
        logic [31:0]  value;
        logic         has_exp;
        freq_result_t exp;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [WIN_BITS-1:0] cfg_data;
    logic                start;
    logic                busy;
    logic [31:0]         item_key;
    logic                result_valid;
    logic [23:0]         item_count;
    logic [23:0]         item_delta;
    logic                newly_entered;
    logic                dropped_full;
    logic                prune_done;
    logic [10:0]         removed_entries;
    logic [10:0]         live_entries;
    logic [10:0]         peak_entries;
    logic [23:0]         current_bucket;

    // Local copy of the table state
    logic [31:0] tbl_key   [TABLE_DEPTH];
    logic        tbl_valid [TABLE_DEPTH];
    logic [23:0] tbl_count [TABLE_DEPTH];
    logic [23:0] tbl_delta [TABLE_DEPTH];
    logic [23:0] win_pos;
    logic [23:0] bucket_num;
    logic [10:0] entry_cnt;
    logic [10:0] entry_max;
    logic [23:0] window_size_q;

    freq_result_t pending_results[$];
    freq_result_t fixed_results[$];
    logic         fixed_flags[$];
    int           mismatch_cnt;
    int           items_taken;
    int           cfg_taken;
    int           quiet_cycles;
    logic         idle_on;
    logic [31:0]  key_pool[12];

    lossy_counting_frequency_table_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .start           (start),
        .busy            (busy),
        .item_key        (item_key),
        .result_valid    (result_valid),
        .item_count      (item_count),
        .item_delta      (item_delta),
        .newly_entered   (newly_entered),
        .dropped_full    (dropped_full),
        .prune_done      (prune_done),
        .removed_entries (removed_entries),
        .live_entries    (live_entries),
        .peak_entries    (peak_entries),
        .current_bucket  (current_bucket)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Update the table for one key and return the expected result
    function automatic freq_result_t count_key(input logic [31:0] key);
        freq_result_t r;
        int hit;
        int free_slot;
        int entered;
        r         = '0;
        hit       = -1;
        free_slot = -1;
        entered   = -1;
        win_pos   = win_pos + 24'd1;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (tbl_valid[i])
            begin
                if (hit < 0 && tbl_key[i] == key)
                    hit = i;
            end
            else if (free_slot < 0)
                free_slot = i;
        end
        if (hit >= 0)
        begin
            if (tbl_count[hit] != COUNT_MAX)
                tbl_count[hit] = tbl_count[hit] + 24'd1;
            r.count = tbl_count[hit];
            r.delta = tbl_delta[hit];
        end
        else if (free_slot >= 0)
        begin
            tbl_valid[free_slot] = 1'b1;
            tbl_key[free_slot]   = key;
            tbl_count[free_slot] = 24'd1;
            tbl_delta[free_slot] = bucket_num - 24'd1;
            entry_cnt            = entry_cnt + 11'd1;
            entered              = free_slot;
            r.count              = 24'd1;
            r.delta              = tbl_delta[free_slot];
            r.newly              = 1'b1;
        end
        else
            r.dropped = 1'b1;
        // Bucket boundary: free stale slots, spare the one just entered
        if (win_pos >= window_size_q)
        begin
            r.pruned = 1'b1;
            if (entry_cnt > entry_max)
                entry_max = entry_cnt;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                if (tbl_valid[i] && i != entered &&
                    ({1'b0, tbl_count[i]} + {1'b0, tbl_delta[i]} <= {1'b0, bucket_num}))
                begin
                    tbl_valid[i] = 1'b0;
                    r.removed    = r.removed + 11'd1;
                end
            end
            entry_cnt = entry_cnt - r.removed;
            win_pos   = '0;
            if (bucket_num != BUCKET_MAX)
                bucket_num = bucket_num + 24'd1;
        end
        r.live   = entry_cnt;
        r.peak   = entry_max;
        r.bucket = bucket_num;
        return r;
    endfunction

    task automatic report(input string field, input logic [31:0] got,
                          input logic [31:0] want);
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field,
                 got, want);
        mismatch_cnt++;
    endtask

    // Take requests and config writes, check results
    always @(posedge clk)
    begin
        freq_result_t want;
        freq_result_t fixed;
        logic         use_fixed;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                want = count_key(item_key);
                if (fixed_flags.size() > 0)
                begin
                    use_fixed = fixed_flags.pop_front();
                    fixed     = fixed_results.pop_front();
                    if (use_fixed && fixed !== want)
                        report("directed row", 32'(items_taken), 32'(items_taken));
                end
                pending_results.push_back(want);
                items_taken++;
            end
            if (cfg_valid && cfg_ready)
            begin
                window_size_q = cfg_data;
                cfg_taken++;
            end
            if (result_valid)
            begin
                if (pending_results.size() == 0)
                    report("unexpected result", 32'd1, 32'd0);
                else
                begin
                    want = pending_results.pop_front();
                    if (item_count !== want.count)
                        report("item_count", 32'(item_count), 32'(want.count));
                    if (item_delta !== want.delta)
                        report("item_delta", 32'(item_delta), 32'(want.delta));
                    if (newly_entered !== want.newly)
                        report("newly_entered", 32'(newly_entered), 32'(want.newly));
                    if (dropped_full !== want.dropped)
                        report("dropped_full", 32'(dropped_full), 32'(want.dropped));
                    if (prune_done !== want.pruned)
                        report("prune_done", 32'(prune_done), 32'(want.pruned));
                    if (removed_entries !== want.removed)
                        report("removed_entries", 32'(removed_entries),
                               32'(want.removed));
                    if (live_entries !== want.live)
                        report("live_entries", 32'(live_entries), 32'(want.live));
                    if (peak_entries !== want.peak)
                        report("peak_entries", 32'(peak_entries), 32'(want.peak));
                    if (current_bucket !== want.bucket)
                        report("current_bucket", 32'(current_bucket), 32'(want.bucket));
                end
            end
        end
    end

    // Watchdog on cycles with no handshake at all
    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((start && !busy) || (cfg_valid && cfg_ready) || result_valid)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("** lossy_counting_frequency_table_core: FAILED **");
                $finish;
            end
        end
    end

    // Send one key and hold until taken; then maybe idle
    task automatic send_key(input logic [31:0] key);
        int seen;
        seen = items_taken;
        start    <= 1'b1;
        item_key <= key;
        while (items_taken == seen)
            @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            start    <= 1'b0;
            item_key <= $urandom;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
    endtask

    // Drain outstanding results, then write window_size
    task automatic write_window(input logic [23:0] value);
        int seen;
        start <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0 || busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
        seen = cfg_taken;
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        while (cfg_taken == seen)
            @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random stream: a small pool of hot keys mixed with wide random keys
    task automatic run_phase(input logic [23:0] window, input int n_items,
                             input int pct_random);
        write_window(window);
        foreach (key_pool[i])
            key_pool[i] = $urandom;
        for (int n = 0; n < n_items; n++)
        begin
            if ($urandom_range(1, 100) <= pct_random)
                send_key($urandom);
            else
                send_key(key_pool[$urandom_range(0, 11)]);
        end
    endtask

    stim_row_t directed_rows[$];

    initial
    begin
        stim_row_t row;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        start         = 1'b0;
        item_key      = '0;
        idle_on       = 1'b1;
        mismatch_cnt  = 0;
        items_taken   = 0;
        cfg_taken     = 0;
        win_pos       = '0;
        bucket_num    = 24'd1;
        entry_cnt     = '0;
        entry_max     = '0;
        window_size_q = 24'd25000;
        foreach (tbl_valid[i])
        begin
            tbl_valid[i] = 1'b0;
            tbl_key[i]   = '0;
            tbl_count[i] = '0;
            tbl_delta[i] = '0;
        end

        // Hand-checked start at the reset window, then window extremes
        directed_rows = '{
            '{ROW_ITEM, 32'h0000_0000, 1'b1, '{24'd1, 24'd0, 1'b1, 1'b0, 1'b0,
                11'd0, 11'd1, 11'd0, 24'd1}},
            '{ROW_ITEM, 32'hFFFF_FFFF, 1'b1, '{24'd1, 24'd0, 1'b1, 1'b0, 1'b0,
                11'd0, 11'd2, 11'd0, 24'd1}},
            '{ROW_ITEM, 32'h0000_0000, 1'b1, '{24'd2, 24'd0, 1'b0, 1'b0, 1'b0,
                11'd0, 11'd2, 11'd0, 24'd1}},
            '{ROW_CFG,  32'd1,         1'b0, '0},
            // Position already past the new window: prune at once
            '{ROW_ITEM, 32'h0000_0005, 1'b1, '{24'd1, 24'd0, 1'b1, 1'b0, 1'b1,
                11'd1, 11'd2, 11'd3, 24'd2}},
            '{ROW_ITEM, 32'h0000_0000, 1'b0, '0},
            '{ROW_ITEM, 32'h8000_0000, 1'b0, '0},
            '{ROW_ITEM, 32'h5555_AAAA, 1'b0, '0},
            '{ROW_ITEM, 32'hAAAA_5555, 1'b0, '0},
            '{ROW_ITEM, 32'h0000_0000, 1'b0, '0},
            '{ROW_ITEM, 32'h0000_0000, 1'b0, '0},
            '{ROW_CFG,  32'hFF_FFFF,   1'b0, '0},
            '{ROW_ITEM, 32'h0000_0001, 1'b0, '0},
            '{ROW_ITEM, 32'h0000_0001, 1'b0, '0},
            '{ROW_ITEM, 32'hFFFF_FFFF, 1'b0, '0},
            '{ROW_CFG,  32'd2,         1'b0, '0},
            '{ROW_ITEM, 32'h0000_0001, 1'b0, '0},
            '{ROW_ITEM, 32'h7FFF_FFFF, 1'b0, '0},
            '{ROW_ITEM, 32'h0000_0001, 1'b0, '0},
            '{ROW_ITEM, 32'h1234_5678, 1'b0, '0}
        };

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Walk the directed table
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_CFG)
                write_window(row.value[23:0]);
            else
            begin
                fixed_flags.push_back(row.has_exp);
                fixed_results.push_back(row.exp);
                send_key(row.value);
            end
        end

        // Random phases; the large window one overfills the table
        run_phase(24'd3, 50, 30);
        run_phase(24'd37, 50, 30);
        run_phase(24'hFF_FFFF, 1150, 95);
        run_phase(24'd1, 50, 30);
        run_phase(24'd200, 50, 30);
        idle_on = 1'b0;
        run_phase(24'($urandom_range(2, 64)), 50, 30);

        // Drain and finish
        start <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (2200) @(negedge clk);
        if (mismatch_cnt == 0)
            $display("** lossy_counting_frequency_table_core: PASSED **");
        else
            $display("** lossy_counting_frequency_table_core: FAILED **");
        $finish;
    end

endmodule
